// File: src/ip_address_classifier_core_macros.svh
// Assertion helpers shared by the RTL.
// They expect clk and rst to be visible where they are used.
`ifndef IP_ADDRESS_CLASSIFIER_CORE_MACROS_SVH
`define IP_ADDRESS_CLASSIFIER_CORE_MACROS_SVH

// Same-cycle implication, muted while rst is high.
`define IPAC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, muted while rst is high.
`define IPAC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/ipac_pkg.sv
`default_nettype none
package ipac_pkg;

  localparam int unsigned WORD_W   = 64;
  localparam int unsigned ADDR_W   = 128;
  localparam int unsigned V4_W     = 32;
  localparam int unsigned PLEN_W   = 8;
  localparam int unsigned CHUNK_W  = 16;
  localparam int unsigned CHUNKS   = ADDR_W / CHUNK_W;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_NET_HI     = 2'd0,
    REG_NET_LO     = 2'd1,
    REG_NET_IS_V6  = 2'd2,
    REG_PREFIX_LEN = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic loopback;
    logic priv;
    logic link_local;
    logic multicast;
    logic bcast;
    logic any;
    logic reserved;
  } flags_t;

  // IPv4 first and second octet values
  localparam logic [7:0] OCT_ZERO      = 8'd0;
  localparam logic [7:0] OCT_TEN       = 8'd10;
  localparam logic [7:0] OCT_LOOPBACK  = 8'd127;
  localparam logic [7:0] OCT_169       = 8'd169;
  localparam logic [7:0] OCT_254       = 8'd254;
  localparam logic [7:0] OCT_172       = 8'd172;
  localparam logic [7:0] OCT_192       = 8'd192;
  localparam logic [7:0] OCT_168       = 8'd168;
  localparam logic [7:0] OCT_MCAST_LO  = 8'd224;
  localparam logic [7:0] OCT_MCAST_HI  = 8'd239;
  localparam logic [7:0] OCT_SHARED    = 8'd100;
  localparam logic [7:0] OCT_198       = 8'd198;
  localparam logic [7:0] OCT_BENCH_LO  = 8'd18;
  localparam logic [7:0] OCT_BENCH_HI  = 8'd19;
  localparam logic [7:0] OCT_203       = 8'd203;
  localparam logic [7:0] OCT_172_LO    = 8'd16;
  localparam logic [7:0] OCT_172_HI    = 8'd31;
  localparam logic [7:0] OCT_SHARED_LO = 8'd64;
  localparam logic [7:0] OCT_SHARED_HI = 8'd127;

  // IPv6 prefixes
  localparam logic [9:0] V6_LINK_LOCAL = 10'h3fa;
  localparam logic [7:0] V6_ULA_MASK   = 8'hfe;
  localparam logic [7:0] V6_ULA        = 8'hfc;
  localparam logic [7:0] V6_MCAST      = 8'hff;

endpackage
`default_nettype wire

// File: src/ipac_flags.sv
`default_nettype none
module ipac_flags (
  input  wire logic                         is_v6,
  input  wire logic [ipac_pkg::WORD_W-1:0]  addr_hi,
  input  wire logic [ipac_pkg::WORD_W-1:0]  addr_lo,
  output ipac_pkg::flags_t                  flags
);

  logic [7:0]               oct_a;
  logic [7:0]               oct_b;
  logic [7:0]               byte0;
  logic [ipac_pkg::V4_W-1:0] a4;
  ipac_pkg::flags_t         f4;
  ipac_pkg::flags_t         f6;

  assign a4    = addr_lo[ipac_pkg::V4_W-1:0];
  assign oct_a = a4[31:24];
  assign oct_b = a4[23:16];
  assign byte0 = addr_hi[63:56];

  always_comb begin
    f4.loopback   = (oct_a == ipac_pkg::OCT_LOOPBACK);
    f4.link_local = (oct_a == ipac_pkg::OCT_169) && (oct_b == ipac_pkg::OCT_254);
    f4.priv       = (oct_a == ipac_pkg::OCT_TEN)
                 || ((oct_a == ipac_pkg::OCT_192) && (oct_b == ipac_pkg::OCT_168))
                 || ((oct_a == ipac_pkg::OCT_172) && (oct_b >= ipac_pkg::OCT_172_LO)
                     && (oct_b <= ipac_pkg::OCT_172_HI))
                 || f4.link_local || f4.loopback;
    f4.multicast  = (oct_a >= ipac_pkg::OCT_MCAST_LO) && (oct_a <= ipac_pkg::OCT_MCAST_HI);
    f4.bcast      = &a4;
    f4.any        = ~|a4;
    f4.reserved   = (oct_a == ipac_pkg::OCT_ZERO) || (oct_a >= ipac_pkg::OCT_MCAST_LO)
                 || ((oct_a == ipac_pkg::OCT_SHARED) && (oct_b >= ipac_pkg::OCT_SHARED_LO)
                     && (oct_b <= ipac_pkg::OCT_SHARED_HI))
                 || ((oct_a == ipac_pkg::OCT_192) && (oct_b == ipac_pkg::OCT_ZERO))
                 || ((oct_a == ipac_pkg::OCT_198) && ((oct_b == ipac_pkg::OCT_BENCH_LO)
                     || (oct_b == ipac_pkg::OCT_BENCH_HI)))
                 || ((oct_a == ipac_pkg::OCT_203) && (oct_b == ipac_pkg::OCT_ZERO));
  end

  always_comb begin
    f6.loopback   = (~|addr_hi) && (addr_lo == 64'd1);
    f6.link_local = (addr_hi[63:54] == ipac_pkg::V6_LINK_LOCAL);
    f6.priv       = ((byte0 & ipac_pkg::V6_ULA_MASK) == ipac_pkg::V6_ULA) || f6.link_local;
    f6.multicast  = (byte0 == ipac_pkg::V6_MCAST);
    f6.bcast      = 1'b0;
    f6.any        = (~|addr_hi) && (~|addr_lo);
    f6.reserved   = 1'b0;
  end

  assign flags = is_v6 ? f6 : f4;

endmodule
`default_nettype wire

// File: src/ipac_mask.sv
`default_nettype none
module ipac_mask (
  input  wire logic                          is_v6,
  input  wire logic [ipac_pkg::PLEN_W-1:0]   prefix_len,
  input  wire logic [ipac_pkg::WORD_W-1:0]   addr_hi,
  input  wire logic [ipac_pkg::WORD_W-1:0]   addr_lo,
  output logic      [ipac_pkg::WORD_W-1:0]   masked_hi,
  output logic      [ipac_pkg::WORD_W-1:0]   masked_lo
);

  logic [ipac_pkg::ADDR_W-1:0] mask6;
  logic [ipac_pkg::V4_W-1:0]   mask4;

  // A shift of the full width or more empties the word, which clamps the length.
  assign mask6 = ~({ipac_pkg::ADDR_W{1'b1}} >> prefix_len);
  assign mask4 = ~({ipac_pkg::V4_W{1'b1}} >> prefix_len);

  always_comb begin
    if (is_v6) begin
      masked_hi = addr_hi & mask6[ipac_pkg::ADDR_W-1:ipac_pkg::WORD_W];
      masked_lo = addr_lo & mask6[ipac_pkg::WORD_W-1:0];
    end else begin
      masked_hi = '0;
      masked_lo = {{(ipac_pkg::WORD_W-ipac_pkg::V4_W){1'b0}},
                   addr_lo[ipac_pkg::V4_W-1:0] & mask4};
    end
  end

endmodule
`default_nettype wire

// File: src/ip_address_classifier_core.sv
// An accepted request passes register stages 1 to 4, the last being the output register.
// Throughput: one request per cycle while out_ready does not stall the output; four
// register stages each hold one request. A stage stalls only while it is full and
// the stage after it is full and not draining. Reset (rst, synchronous, active high)
// empties every stage and clears the configuration registers to zero.
`default_nettype none
`include "ip_address_classifier_core_macros.svh"
module ip_address_classifier_core (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // configuration write port
  input  wire logic                         wr_en,
  input  wire logic [1:0]                   wr_index,
  input  wire logic [ipac_pkg::WORD_W-1:0]  wr_data,
  // request channel
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         is_v6,
  input  wire logic [ipac_pkg::WORD_W-1:0]  addr_hi,
  input  wire logic [ipac_pkg::WORD_W-1:0]  addr_lo,
  // result channel
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              is_loopback,
  output logic                              is_private,
  output logic                              is_link_local,
  output logic                              is_multicast,
  output logic                              is_bcast,
  output logic                              is_any,
  output logic                              is_reserved,
  output logic                              prefix_match,
  output logic [ipac_pkg::WORD_W-1:0]       masked_hi,
  output logic [ipac_pkg::WORD_W-1:0]       masked_lo
);

  // ---------------------------------------------------------------------------
  // Configuration registers. The user must write them only while the pipeline is
  // empty (the block does not enforce this), so the stages read them directly.
  // ---------------------------------------------------------------------------
  logic [ipac_pkg::WORD_W-1:0] net_hi;
  logic [ipac_pkg::WORD_W-1:0] net_lo;
  logic                        net_is_v6;
  logic [ipac_pkg::PLEN_W-1:0] prefix_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      net_hi     <= '0;
      net_lo     <= '0;
      net_is_v6  <= 1'b0;
      prefix_len <= '0;
    end else if (wr_en) begin
      unique case (ipac_pkg::reg_idx_t'(wr_index))
        ipac_pkg::REG_NET_HI:     net_hi     <= wr_data;
        ipac_pkg::REG_NET_LO:     net_lo     <= wr_data;
        ipac_pkg::REG_NET_IS_V6:  net_is_v6  <= wr_data[0];
        ipac_pkg::REG_PREFIX_LEN: prefix_len <= wr_data[ipac_pkg::PLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Reference network masked once, combinationally from the static registers.
  logic [ipac_pkg::WORD_W-1:0] net_m_hi;
  logic [ipac_pkg::WORD_W-1:0] net_m_lo;

  ipac_mask u_net_mask (
    .is_v6      (net_is_v6),
    .prefix_len (prefix_len),
    .addr_hi    (net_hi),
    .addr_lo    (net_lo),
    .masked_hi  (net_m_hi),
    .masked_lo  (net_m_lo)
  );

  // ---------------------------------------------------------------------------
  // Stage readiness: a stage takes new data when it is empty or its content
  // moves on in the same cycle. Valid bits travel with the data.
  // ---------------------------------------------------------------------------
  logic s1_valid;
  logic s2_valid;
  logic s3_valid;
  logic s1_ready;
  logic s2_ready;
  logic s3_ready;
  logic s4_ready;

  assign s4_ready = !out_valid || out_ready;
  assign s3_ready = !s3_valid  || s4_ready;
  assign s2_ready = !s2_valid  || s3_ready;
  assign s1_ready = !s1_valid  || s2_ready;
  assign in_ready = s1_ready;

  // ---------------------------------------------------------------------------
  // Stage 1: capture the request.
  // ---------------------------------------------------------------------------
  logic                        s1_v6;
  logic [ipac_pkg::WORD_W-1:0] s1_hi;
  logic [ipac_pkg::WORD_W-1:0] s1_lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_v6 <= is_v6;
      s1_hi <= addr_hi;
      s1_lo <= addr_lo;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: decode the class flags and mask the address to the prefix.
  // ---------------------------------------------------------------------------
  ipac_pkg::flags_t            s1_flags;
  logic [ipac_pkg::WORD_W-1:0] s1_m_hi;
  logic [ipac_pkg::WORD_W-1:0] s1_m_lo;

  ipac_flags u_flags (
    .is_v6   (s1_v6),
    .addr_hi (s1_hi),
    .addr_lo (s1_lo),
    .flags   (s1_flags)
  );

  ipac_mask u_addr_mask (
    .is_v6      (s1_v6),
    .prefix_len (prefix_len),
    .addr_hi    (s1_hi),
    .addr_lo    (s1_lo),
    .masked_hi  (s1_m_hi),
    .masked_lo  (s1_m_lo)
  );

  logic                        s2_v6;
  ipac_pkg::flags_t            s2_flags;
  logic [ipac_pkg::WORD_W-1:0] s2_m_hi;
  logic [ipac_pkg::WORD_W-1:0] s2_m_lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      s2_v6    <= s1_v6;
      s2_flags <= s1_flags;
      s2_m_hi  <= s1_m_hi;
      s2_m_lo  <= s1_m_lo;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: compare against the masked network in 16-bit slices.
  // ---------------------------------------------------------------------------
  logic [ipac_pkg::ADDR_W-1:0] s2_addr_m;
  logic [ipac_pkg::ADDR_W-1:0] net_m;
  logic [ipac_pkg::CHUNKS-1:0] s2_eq;

  assign s2_addr_m = {s2_m_hi, s2_m_lo};
  assign net_m     = {net_m_hi, net_m_lo};

  always_comb begin
    for (int k = 0; k < ipac_pkg::CHUNKS; k++) begin
      s2_eq[k] = (s2_addr_m[k*ipac_pkg::CHUNK_W +: ipac_pkg::CHUNK_W]
               == net_m[k*ipac_pkg::CHUNK_W +: ipac_pkg::CHUNK_W]);
    end
  end

  logic                        s3_fam_eq;
  logic [ipac_pkg::CHUNKS-1:0] s3_eq;
  ipac_pkg::flags_t            s3_flags;
  logic [ipac_pkg::WORD_W-1:0] s3_m_hi;
  logic [ipac_pkg::WORD_W-1:0] s3_m_lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_ready) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && s2_valid) begin
      s3_fam_eq <= (s2_v6 == net_is_v6);
      s3_eq     <= s2_eq;
      s3_flags  <= s2_flags;
      s3_m_hi   <= s2_m_hi;
      s3_m_lo   <= s2_m_lo;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: reduce the slice compares and hold the result for the consumer.
  // ---------------------------------------------------------------------------
  ipac_pkg::flags_t out_flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s4_ready) begin
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_ready && s3_valid) begin
      out_flags    <= s3_flags;
      prefix_match <= s3_fam_eq && (&s3_eq);
      masked_hi    <= s3_m_hi;
      masked_lo    <= s3_m_lo;
    end
  end

  assign is_loopback   = out_flags.loopback;
  assign is_private    = out_flags.priv;
  assign is_link_local = out_flags.link_local;
  assign is_multicast  = out_flags.multicast;
  assign is_bcast      = out_flags.bcast;
  assign is_any        = out_flags.any;
  assign is_reserved   = out_flags.reserved;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `IPAC_ASSERT_NEXT(a_accept_fills_s1, in_valid && in_ready, s1_valid, "accepted request lost at stage 1")
  `IPAC_ASSERT_NEXT(a_s3_hold, s3_valid && !s4_ready, s3_valid && $stable(s3_eq) && $stable(s3_fam_eq), "stage 3 changed while stalled")
  `IPAC_ASSERT_SAME(a_link_local_private, out_valid && is_link_local, is_private, "link-local result not marked private")
  `IPAC_ASSERT_SAME(a_bcast_v4, out_valid && is_bcast, is_reserved && (masked_hi == '0) && !is_any, "broadcast result inconsistent")

endmodule
`default_nettype wire

// File: bench/ip_address_classifier_core_tb.sv
`timescale 1ns / 100ps
module ip_address_classifier_core_tb;
  import ipac_pkg::*;

  // Watchdog: far above the slowest legal run (about 460 requests, each with
  // the longest drawn gap and stall, through the 4-stage pipeline).
  localparam int unsigned CYCLE_LIMIT = 200000;

  // One address request as the sender presents it
  typedef struct {
    bit        v6;
    bit [63:0] hi;
    bit [63:0] lo;
  } ip_req_t;

  // What the block should answer for one request
  typedef struct {
    flags_t    flags;
    bit        match;
    bit [63:0] mhi;
    bit [63:0] mlo;
  } ip_verdict_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      wr_en = 1'b0;
  reg_idx_t  wr_index = REG_NET_HI;
  logic [63:0] wr_data = '0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  logic      is_v6 = 1'b0;
  logic [63:0] addr_hi = '0;
  logic [63:0] addr_lo = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  logic      is_loopback, is_private, is_link_local, is_multicast;
  logic      is_bcast, is_any, is_reserved, prefix_match;
  logic [63:0] masked_hi, masked_lo;

  // Mirror of the configuration registers
  bit [63:0] net_hi_cfg = '0;
  bit [63:0] net_lo_cfg = '0;
  bit        net_v6_cfg = 1'b0;
  bit [7:0]  plen_cfg = '0;

  ip_req_t     address_backlog[$];
  ip_verdict_t predicted_classes[$];
  int unsigned requests_queued = 0;
  int unsigned requests_taken = 0;
  int unsigned cycle_count = 0;
  bit          failed = 1'b0;

  // Handshake flags seen at the last rising edge, read by the drivers
  bit req_taken = 1'b0;
  bit res_taken = 1'b0;

  // Idle control for both sides; a calm side never idles
  int unsigned req_gap = 0;
  int unsigned res_stall = 0;
  bit          src_calm = 1'b0;
  bit          sink_calm = 1'b1;
  ip_req_t     next_req;

  ip_address_classifier_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .wr_en         (wr_en),
    .wr_index      (wr_index),
    .wr_data       (wr_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .is_v6         (is_v6),
    .addr_hi       (addr_hi),
    .addr_lo       (addr_lo),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .is_loopback   (is_loopback),
    .is_private    (is_private),
    .is_link_local (is_link_local),
    .is_multicast  (is_multicast),
    .is_bcast      (is_bcast),
    .is_any        (is_any),
    .is_reserved   (is_reserved),
    .prefix_match  (prefix_match),
    .masked_hi     (masked_hi),
    .masked_lo     (masked_lo)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic bit [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic int unsigned draw_wait(input bit calm);
    return calm ? 0 : $urandom_range(0, 12);
  endfunction

  // Prefix masks, with the length clamped to the family's width
  function automatic bit [127:0] v6_mask(input bit [7:0] plen);
    int unsigned n;
    n = (plen > 128) ? 128 : plen;
    if (n == 0) return '0;
    return {128{1'b1}} << (128 - n);
  endfunction

  function automatic bit [31:0] v4_mask(input bit [7:0] plen);
    int unsigned n;
    n = (plen > 32) ? 32 : plen;
    if (n == 0) return '0;
    return {32{1'b1}} << (32 - n);
  endfunction

  // IPv4 keeps only bits 31..0 of the low word; everything else reads as zero
  function automatic bit [127:0] masked_addr(input bit v6, input bit [63:0] hi, lo);
    if (v6) return {hi, lo} & v6_mask(plen_cfg);
    return {96'b0, lo[31:0] & v4_mask(plen_cfg)};
  endfunction

  function automatic ip_verdict_t classify_request(input bit v6, input bit [63:0] hi, lo);
    ip_verdict_t v;
    bit [7:0]    a;
    bit [7:0]    b;
    bit [127:0]  own;
    bit [127:0]  net_m;
    a = lo[31:24];
    b = lo[23:16];
    v.flags = '0;
    if (v6) begin
      v.flags.loopback   = (hi == 64'd0) && (lo == 64'd1);
      v.flags.link_local = hi[63:54] == V6_LINK_LOCAL;
      v.flags.priv       = ((hi[63:56] & V6_ULA_MASK) == V6_ULA) || v.flags.link_local;
      v.flags.multicast  = hi[63:56] == V6_MCAST;
      v.flags.any        = (hi == 64'd0) && (lo == 64'd0);
    end else begin
      v.flags.loopback   = a == OCT_LOOPBACK;
      v.flags.link_local = (a == OCT_169) && (b == OCT_254);
      v.flags.priv       = (a == OCT_TEN) || ((a == OCT_192) && (b == OCT_168)) ||
                           ((a == OCT_172) && (b >= OCT_172_LO) && (b <= OCT_172_HI)) ||
                           v.flags.link_local || v.flags.loopback;
      v.flags.multicast  = (a >= OCT_MCAST_LO) && (a <= OCT_MCAST_HI);
      v.flags.bcast      = lo[31:0] == 32'hffff_ffff;
      v.flags.any        = lo[31:0] == 32'd0;
      v.flags.reserved   = (a == OCT_ZERO) || (a >= OCT_MCAST_LO) ||
                           ((a == OCT_SHARED) && (b >= OCT_SHARED_LO) && (b <= OCT_SHARED_HI)) ||
                           ((a == OCT_192) && (b == OCT_ZERO)) ||
                           ((a == OCT_198) && ((b == OCT_BENCH_LO) || (b == OCT_BENCH_HI))) ||
                           ((a == OCT_203) && (b == OCT_ZERO));
    end
    own   = masked_addr(v6, hi, lo);
    net_m = masked_addr(net_v6_cfg, net_hi_cfg, net_lo_cfg);
    {v.mhi, v.mlo} = own;
    v.match = (v6 == net_v6_cfg) && (own == net_m);
    return v;
  endfunction

  function automatic ip_req_t v4_req(input bit [31:0] a4);
    ip_req_t r;
    r.v6 = 1'b0;
    r.hi = '0;
    r.lo = {32'd0, a4};
    return r;
  endfunction

  function automatic ip_req_t v6_req(input bit [63:0] hi, lo);
    ip_req_t r;
    r.v6 = 1'b1;
    r.hi = hi;
    r.lo = lo;
    return r;
  endfunction

  // Address inside the configured network: keep the prefix, randomize the host
  // part. Flip the family now and then so mismatches show up.
  function automatic ip_req_t near_network();
    ip_req_t    r;
    bit [127:0] noise;
    bit [127:0] m;
    bit [31:0]  m4;
    noise = {rand64(), rand64()};
    if (net_v6_cfg) begin
      m = v6_mask(plen_cfg);
      r.v6 = 1'b1;
      {r.hi, r.lo} = ({net_hi_cfg, net_lo_cfg} & m) | (noise & ~m);
    end else begin
      m4 = v4_mask(plen_cfg);
      r.v6 = 1'b0;
      r.hi = noise[127:64];
      r.lo = {noise[63:32], (net_lo_cfg[31:0] & m4) | (noise[31:0] & ~m4)};
    end
    if ($urandom_range(0, 9) == 0) r.v6 = !r.v6;
    return r;
  endfunction

  // Address aimed at the class boundaries of either family
  function automatic ip_req_t typical_addr();
    ip_req_t  r;
    bit [7:0] a;
    bit [7:0] b;
    r.v6 = 1'($urandom_range(0, 1));
    r.hi = rand64();
    r.lo = rand64();
    if (!r.v6) begin
      case ($urandom_range(0, 13))
        0: b = 8'd0;    1: b = 8'd15;   2: b = 8'd16;   3: b = 8'd31;
        4: b = 8'd32;   5: b = 8'd63;   6: b = 8'd64;   7: b = 8'd127;
        8: b = 8'd128;  9: b = 8'd168;  10: b = 8'd254; 11: b = 8'd18;
        12: b = 8'd19;  default: b = 8'($urandom_range(0, 255));
      endcase
      case ($urandom_range(0, 12))
        0: a = OCT_ZERO;      1: a = OCT_TEN;  2: a = OCT_LOOPBACK;
        3: a = OCT_169;       4: a = OCT_172;  5: a = OCT_192;
        6: a = OCT_198;       7: a = OCT_203;  8: a = OCT_SHARED;
        9: a = 8'($urandom_range(223, 255));
        default: a = 8'($urandom_range(0, 255));
      endcase
      r.lo[31:16] = {a, b};
      case ($urandom_range(0, 15))
        0: r.lo[31:0] = 32'hffff_ffff;
        1: r.lo[31:0] = 32'd0;
        default: ;
      endcase
      // Unused upper bits: half the time zero, half the time noise
      if ($urandom_range(0, 1) == 0) begin
        r.hi = '0;
        r.lo[63:32] = '0;
      end
    end else begin
      case ($urandom_range(0, 8))
        0: r.hi[63:54] = V6_LINK_LOCAL;
        1: r.hi[63:57] = V6_ULA[7:1];
        2: r.hi[63:56] = V6_MCAST;
        3: r.hi[63:56] = 8'hfe;
        4: begin
          r.hi = '0;
          r.lo = 64'($urandom_range(0, 3));
        end
        5: begin
          r.hi = '0;
          r.lo = '0;
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  task automatic queue_request(input ip_req_t r);
    address_backlog.insert(address_backlog.size(), r);
    requests_queued++;
  endtask

  // Wait until every queued request has been taken and answered
  task automatic wait_idle();
    while (requests_taken != requests_queued || predicted_classes.size() != 0)
      @(negedge clk);
  endtask

  // Drive one register write for the next rising edge and track it in the mirror
  task automatic write_reg(input reg_idx_t idx, input bit [63:0] val);
    @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    case (idx)
      REG_NET_HI:     net_hi_cfg = val;
      REG_NET_LO:     net_lo_cfg = val;
      REG_NET_IS_V6:  net_v6_cfg = val[0];
      REG_PREFIX_LEN: plen_cfg   = val[7:0];
      default: ;
    endcase
  endtask

  // Reprogram the network once the block has drained, then queue a random batch
  task automatic run_phase(input bit nv6, input bit [7:0] plen, input int count);
    bit [63:0] w;
    int        pick;
    wait_idle();
    w = rand64();
    if ($urandom_range(0, 3) == 0) w = '0;
    write_reg(REG_NET_HI, w);
    write_reg(REG_NET_LO, rand64());
    // Registers narrower than the port ignore the upper data bits
    w = ($urandom_range(0, 1) == 0) ? rand64() : '0;
    w[0] = nv6;
    write_reg(REG_NET_IS_V6, w);
    w = ($urandom_range(0, 1) == 0) ? rand64() : '0;
    w[7:0] = plen;
    write_reg(REG_PREFIX_LEN, w);
    @(negedge clk);
    wr_en <= 1'b0;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 4)      queue_request(near_network());
      else if (pick < 8) queue_request(typical_addr());
      else               queue_request(v6_req(rand64(), rand64()));
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want, got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      failed = 1'b1;
    end
  endtask

  // Request side: present the next address, hold it until taken, then idle
  // for the drawn gap before the following one.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      if (req_gap > 0) begin
        in_valid <= 1'b0;
        req_gap--;
      end else if (address_backlog.size() != 0) begin
        next_req = address_backlog.pop_front();
        is_v6    <= next_req.v6;
        addr_hi  <= next_req.hi;
        addr_lo  <= next_req.lo;
        in_valid <= 1'b1;
        req_gap  = draw_wait(src_calm);
        if ($urandom_range(0, 29) == 0) src_calm = !src_calm;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side: after each taken result, stall for a drawn number of cycles
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (res_taken) begin
        res_stall = draw_wait(sink_calm);
        if ($urandom_range(0, 29) == 0) sink_calm = !sink_calm;
      end
      if (res_stall > 0) begin
        out_ready <= 1'b0;
        res_stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Predict on every taken request, compare on every taken result
  always @(posedge clk) begin
    ip_verdict_t want;
    if (rst) begin
      req_taken = 1'b0;
      res_taken = 1'b0;
    end else begin
      req_taken = in_valid && in_ready;
      res_taken = out_valid && out_ready;
      if (req_taken) begin
        predicted_classes.insert(predicted_classes.size(),
                                 classify_request(is_v6, addr_hi, addr_lo));
        requests_taken++;
      end
      if (res_taken) begin
        if (predicted_classes.size() == 0) begin
          $error("result with no request outstanding");
          failed = 1'b1;
        end else begin
          want = predicted_classes.pop_front();
          check_field("is_loopback", want.flags.loopback, is_loopback);
          check_field("is_private", want.flags.priv, is_private);
          check_field("is_link_local", want.flags.link_local, is_link_local);
          check_field("is_multicast", want.flags.multicast, is_multicast);
          check_field("is_bcast", want.flags.bcast, is_bcast);
          check_field("is_any", want.flags.any, is_any);
          check_field("is_reserved", want.flags.reserved, is_reserved);
          check_field("prefix_match", want.match, prefix_match);
          check_field("masked_hi", want.mhi, masked_hi);
          check_field("masked_lo", want.mlo, masked_lo);
        end
      end
    end
  end

  initial begin
    ip_req_t r;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    // Directed pass on the reset configuration: IPv4 network 0/0, so every
    // IPv4 address matches and every IPv6 address is a family mismatch.
    r = v4_req(32'h0000_0000);
    r.hi = '1;
    r.lo[63:32] = '1;
    queue_request(r);                      // any, with noise in the unused bits
    queue_request(v4_req(32'hffff_ffff));  // broadcast
    queue_request(v4_req(32'h7f00_0001));
    queue_request(v4_req(32'h0a01_0203));
    queue_request(v4_req(32'hac10_0001));
    queue_request(v4_req(32'hac1f_ffff));
    queue_request(v4_req(32'hac20_0001));
    queue_request(v4_req(32'hc0a8_0101));
    queue_request(v4_req(32'ha9fe_0304));
    queue_request(v4_req(32'he000_0001));
    queue_request(v4_req(32'hefff_ffff));
    queue_request(v4_req(32'hf000_0001));
    queue_request(v4_req(32'h6440_0000));
    queue_request(v4_req(32'h647f_ffff));
    queue_request(v4_req(32'h6480_0000));
    queue_request(v4_req(32'hc000_0201));
    queue_request(v4_req(32'hc612_0001));
    queue_request(v4_req(32'hc613_0001));
    queue_request(v4_req(32'hcb00_7101));
    queue_request(v6_req(64'd0, 64'd0));
    queue_request(v6_req(64'd0, 64'd1));
    queue_request(v6_req(64'hfe80_0000_0000_0000, 64'd1));
    queue_request(v6_req(64'hfec0_0000_0000_0000, 64'd0));
    queue_request(v6_req(64'hfdff_ffff_ffff_ffff, 64'd5));
    queue_request(v6_req(64'hff02_0000_0000_0000, 64'd1));
    queue_request(v6_req('1, '1));

    // Random batches over a spread of networks and prefix lengths,
    // including zero, exact width and clamped lengths.
    run_phase(1'b0, 8'd24, 39);
    run_phase(1'b0, 8'd200, 39);
    run_phase(1'b1, 8'd64, 39);
    run_phase(1'b1, 8'd128, 39);
    run_phase(1'b1, 8'd255, 39);
    run_phase(1'b1, 8'd0, 39);
    run_phase(1'b0, 8'd32, 39);
    run_phase(1'b0, 8'd33, 39);
    run_phase(1'b1, 8'($urandom_range(1, 127)), 39);
    run_phase(1'b0, 8'd0, 39);
    run_phase(1'b1, 8'd129, 39);

    // Drain, then give any stray result time to show up
    wait_idle();
    repeat (12) @(negedge clk);
    if (!failed)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// File: sim.f
+incdir+src
src/ipac_pkg.sv
src/ipac_flags.sv
src/ipac_mask.sv
src/ip_address_classifier_core.sv
bench/ip_address_classifier_core_tb.sv
